[design/assert_macros.svh]
// assertion macros for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define SFEA_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sfea assertion failed");

// next-cycle implication
`define SFEA_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sfea assertion failed");

`endif

[design/sfea_pkg.sv]
package sfea_pkg;

    localparam int SFEA_ENTRIES = 20;
    localparam int LEN_W        = 15;
    localparam int OFS_W        = 31;

    typedef struct packed {
        logic [LEN_W-1:0] len;
        logic [OFS_W-1:0] ofs;
        logic             used;
    } t_entry;

endpackage

[design/sfea_cell.sv]
module sfea_cell import sfea_pkg::*; (
    input  logic             i_clk,
    input  logic             i_valid,
    input  logic             i_rel_en,
    input  logic             i_gnt_en,
    input  logic [LEN_W-1:0] i_new_len,
    input  logic [OFS_W-1:0] i_new_ofs,
    input  logic [LEN_W-1:0] i_req_len,
    input  t_entry           i_left,
    input  t_entry           i_right,
    output t_entry           o_entry,
    input  logic             i_pre,
    output logic             o_pre,
    input  logic             i_b_right,
    output logic             o_b,
    input  logic             i_less_left,
    output logic             o_less,
    input  logic             i_gpre,
    output logic             o_gpre,
    output logic             o_gsel
);

    t_entry r_entry;
    t_entry n_entry;
    t_entry w_new;
    logic   w_hit;
    logic   w_is_slot;
    logic   w_is_ins;
    logic   w_cand;

    assign o_entry = r_entry;

    // release: slot is first used or first empty cell
    assign w_hit     = !i_valid || r_entry.used;
    assign o_pre     = i_pre && !w_hit;
    assign w_is_slot = i_pre && w_hit;

    // entry sorts ahead of the new extent
    assign o_b = i_valid && !w_is_slot &&
                 ((r_entry.len < i_new_len) || ((r_entry.len == i_new_len) && o_pre));

    assign o_less   = o_pre ? o_b : i_b_right;
    assign w_is_ins = !o_less && i_less_left;

    assign w_new.len  = i_new_len;
    assign w_new.ofs  = i_new_ofs;
    assign w_new.used = 1'b0;

    always_comb begin
        if (o_less) begin
            n_entry = o_pre ? r_entry : i_right;
        end else if (w_is_ins) begin
            n_entry = w_new;
        end else begin
            n_entry = i_pre ? i_left : r_entry;
        end
    end

    // grant: first unused entry that is long enough
    assign w_cand = i_valid && !r_entry.used && (r_entry.len >= i_req_len);
    assign o_gsel = i_gpre && w_cand;
    assign o_gpre = i_gpre && !w_cand;

    always_ff @(posedge i_clk) begin
        if (i_rel_en) begin
            r_entry <= n_entry;
        end else if (i_gnt_en && o_gsel) begin
            r_entry.used <= 1'b1;
        end
    end

endmodule

[design/sorted_free_extent_allocator_core.sv]
// Best-fit free extent allocator. A row of TABLE_ENTRIES cells holds the free
// extents sorted by ascending length, equal lengths in arrival order. An item
// has a release step and a grant step: first, a returned extent (nonzero offset)
// replaces the first used entry or is appended, and every cell moves its entry
// left, right or keeps it in one step to restore the order; then the first
// unused entry long enough is marked used and reported. The next item is taken
// in the grant cycle while the output is free, so items overlap their results.
module sorted_free_extent_allocator_core import sfea_pkg::*; #(
    parameter int TABLE_ENTRIES = SFEA_ENTRIES
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  logic [LEN_W-1:0] i_request_len,
    input  logic [LEN_W-1:0] i_release_len,
    input  logic [OFS_W-1:0] i_release_offset,
    output logic             o_valid,
    input  logic             i_stall,
    output logic             o_found,
    output logic [OFS_W-1:0] o_offset,
    output logic [LEN_W-1:0] o_granted_len,
    output logic             o_release_stored
);

    localparam int CW = $clog2(TABLE_ENTRIES + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_REL  = 2'd1;
    localparam logic [1:0] ST_GNT  = 2'd2;

    logic [1:0]       r_state, n_state;
    logic [CW-1:0]    r_count, n_count;
    logic             r_o_valid, n_o_valid;
    logic [LEN_W-1:0] r_req;
    logic [LEN_W-1:0] r_rlen;
    logic [OFS_W-1:0] r_rofs;
    logic             r_stored;
    logic             r_o_found;
    logic [OFS_W-1:0] r_o_ofs;
    logic [LEN_W-1:0] r_o_len;
    logic             r_o_stored;

    t_entry           w_ent  [0:TABLE_ENTRIES+1];
    logic             w_pre  [0:TABLE_ENTRIES];
    logic             w_b    [0:TABLE_ENTRIES];
    logic             w_less [0:TABLE_ENTRIES];
    logic             w_gpre [0:TABLE_ENTRIES];
    logic             w_gsel [0:TABLE_ENTRIES-1];
    logic             w_valid[0:TABLE_ENTRIES-1];
    logic             w_last [0:TABLE_ENTRIES-1];

    logic             w_accept;
    logic             w_out_free;
    logic             w_rel_do;
    logic             w_rel_en;
    logic             w_gnt_en;
    logic             w_any_used;
    logic             w_dec;
    logic [OFS_W-1:0] w_gofs;
    logic [LEN_W-1:0] w_glen;

    assign w_ent[0]              = '0;
    assign w_ent[TABLE_ENTRIES+1] = '0;
    assign w_pre[0]              = 1'b1;
    assign w_b[TABLE_ENTRIES]    = 1'b0;
    assign w_less[0]             = 1'b1;
    assign w_gpre[0]             = 1'b1;

    assign w_out_free = !r_o_valid || !i_stall;
    assign o_stall    = !((r_state == ST_IDLE) || ((r_state == ST_GNT) && w_out_free));
    assign w_accept   = i_valid && !o_stall;

    assign w_rel_do = (r_state == ST_REL) && (r_rofs != '0) && !w_pre[TABLE_ENTRIES];
    assign w_rel_en = w_rel_do;
    assign w_gnt_en = (r_state == ST_GNT) && w_out_free;

    for (genvar k = 0; k < TABLE_ENTRIES; k++) begin : g_cell
        assign w_valid[k] = r_count > CW'(k);
        assign w_last[k]  = r_count == CW'(k + 1);

        sfea_cell u_cell (
            .i_clk       (i_clk),
            .i_valid     (w_valid[k]),
            .i_rel_en    (w_rel_en),
            .i_gnt_en    (w_gnt_en),
            .i_new_len   (r_rlen),
            .i_new_ofs   (r_rofs),
            .i_req_len   (r_req),
            .i_left      (w_ent[k]),
            .i_right     (w_ent[k+2]),
            .o_entry     (w_ent[k+1]),
            .i_pre       (w_pre[k]),
            .o_pre       (w_pre[k+1]),
            .i_b_right   (w_b[k+1]),
            .o_b         (w_b[k]),
            .i_less_left (w_less[k]),
            .o_less      (w_less[k+1]),
            .i_gpre      (w_gpre[k]),
            .o_gpre      (w_gpre[k+1]),
            .o_gsel      (w_gsel[k])
        );
    end

    always_comb begin
        w_any_used = 1'b0;
        w_dec      = 1'b0;
        w_gofs     = '0;
        w_glen     = '0;
        for (int k = 0; k < TABLE_ENTRIES; k++) begin
            w_any_used = w_any_used | (w_valid[k] & w_ent[k+1].used);
            w_dec      = w_dec | (w_gsel[k] & w_last[k]);
            w_gofs     = w_gofs | (w_ent[k+1].ofs & {OFS_W{w_gsel[k]}});
            w_glen     = w_glen | (w_ent[k+1].len & {LEN_W{w_gsel[k]}});
        end
    end

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_o_valid = r_o_valid;
        if (r_o_valid && !i_stall) begin
            n_o_valid = 1'b0;
        end
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = ST_REL;
                end
            end
            ST_REL: begin
                if (w_rel_do && !w_any_used) begin
                    n_count = r_count + CW'(1);
                end
                n_state = ST_GNT;
            end
            ST_GNT: begin
                if (w_out_free) begin
                    n_o_valid = 1'b1;
                    if (w_dec) begin
                        n_count = r_count - CW'(1);
                    end
                    n_state = w_accept ? ST_REL : ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_count   <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req  <= i_request_len;
            r_rlen <= i_release_len;
            r_rofs <= i_release_offset;
        end
        if (r_state == ST_REL) begin
            r_stored <= w_rel_do;
        end
        if (w_gnt_en) begin
            r_o_found  <= w_glen != '0;
            r_o_ofs    <= (w_glen != '0) ? w_gofs : '0;
            r_o_len    <= w_glen;
            r_o_stored <= r_stored;
        end
    end

    assign o_valid          = r_o_valid;
    assign o_found          = r_o_found;
    assign o_offset         = r_o_ofs;
    assign o_granted_len    = r_o_len;
    assign o_release_stored = r_o_stored;

endmodule

[design/sfea_checker.sv]
`include "assert_macros.svh"

module sfea_checker import sfea_pkg::*; (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_valid,
    input logic             o_stall,
    input logic [LEN_W-1:0] i_request_len,
    input logic [LEN_W-1:0] i_release_len,
    input logic [OFS_W-1:0] i_release_offset,
    input logic             o_valid,
    input logic             i_stall,
    input logic             o_found,
    input logic [OFS_W-1:0] o_offset,
    input logic [LEN_W-1:0] o_granted_len,
    input logic             o_release_stored
);

    logic w_in_acc;

    assign w_in_acc = i_valid && !o_stall;

    // a grant always carries a nonzero length
    `SFEA_ASSERT_IMP(a_found_len, i_clk, i_rst_n, o_valid && o_found, o_granted_len != '0)

    // a failure reports zero offset and length
    `SFEA_ASSERT_IMP(a_fail_zero, i_clk, i_rst_n, o_valid && !o_found,
        (o_offset == '0) && (o_granted_len == '0))

    // the release cycle follows every accepted item
    `SFEA_ASSERT_NXT(a_busy_after_acc, i_clk, i_rst_n, w_in_acc, o_stall)

    // a stalled result holds
    `SFEA_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall,
        o_valid && $stable(o_offset) && $stable(o_found) && $stable(o_release_stored))

endmodule

bind sorted_free_extent_allocator_core sfea_checker u_sfea_checker (.*);
